// ===== rtl/kee_pkg.sv =====
// Shared types and constants for the keypad event engine.
// Used by kee_alu, kee_fifo and keypad_event_engine_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package kee_pkg;

	localparam int NUM_KEYS   = 16;
	localparam int KEY_W      = $clog2(NUM_KEYS);
	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int QCNT_W     = $clog2(FIFO_DEPTH + 1);
	localparam int CNT_W      = 8;
	localparam int CW_W       = 4;
	localparam int ADDR_W     = 4;

	localparam logic [CNT_W-1:0] LONG_AT       = 8'd20;
	localparam logic [CNT_W-1:0] DOUBLE_WINDOW = 8'd8;

	// Register indexes (byte address / 4).
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_THRESH = 2'd1;
	localparam logic [1:0] REG_GAP    = 2'd2;

	typedef enum logic [2:0] {
		EV_PRESS   = 3'd0,
		EV_RELEASE = 3'd1,
		EV_HOLD    = 3'd2,
		EV_LONG    = 3'd3,
		EV_DOUBLE  = 3'd4
	} ev_kind_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DOWN = 2'd1,
		PH_HOLD = 2'd2
	} ph_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		ev_kind_t         kind;
	} ev_t;

	typedef struct packed {
		logic valid;
		ev_t  ev;
	} push_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             inc;
		logic [CNT_W-1:0] sub;
		logic [CNT_W-1:0] lim;
	} alu_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] sum;
		logic             ge;
	} alu_rsp_t;

	typedef struct packed {
		logic        req_type;
		logic [15:0] raw_keys;
	} req_t;

	typedef struct packed {
		logic [15:0]       keys_now;
		logic              event_valid;
		logic [3:0]        event_key;
		logic [2:0]        event_type;
		logic [QCNT_W-1:0] queue_count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/kee_alu.sv =====
// Shared counter unit of the keypad event engine: 8-bit increment followed by a
// signed compare of (count - sub) against a limit. Depends on kee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kee_alu
	import kee_pkg::*;
(
	input  alu_req_t op,
	output alu_rsp_t res
);

	logic [CNT_W-1:0]  sum;
	logic signed [9:0] diff;

	// The sum wraps at eight bits, the difference is the true signed one.
	assign sum  = op.cnt + {{(CNT_W-1){1'b0}}, op.inc};
	assign diff = $signed({2'b00, sum}) - $signed({2'b00, op.sub});

	assign res.sum = sum;
	assign res.ge  = (diff >= $signed({2'b00, op.lim}));

endmodule

`default_nettype wire

// ===== rtl/kee_fifo.sv =====
// Event queue of the keypad event engine: a memory with head, tail and count,
// registered read data, full pushes dropped. Depends on kee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kee_fifo
	import kee_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  push_t             push,
	input  logic              pop,
	output ev_t               rd_data,
	output logic [QCNT_W-1:0] count
);

	ev_t               mem [FIFO_DEPTH];
	ev_t               rd_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [QCNT_W-1:0] count_q;
	logic              wr_en;
	logic              rd_en;

	assign wr_en = push.valid && (count_q != QCNT_W'(FIFO_DEPTH));
	assign rd_en = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[head_q] <= push.ev;
		end
		if (rd_en) begin
			rd_q <= mem[tail_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (clear) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				head_q <= (head_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
			end
			if (rd_en) begin
				tail_q <= (tail_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	assign rd_data = rd_q;
	assign count   = count_q;

endmodule

`default_nettype wire

// ===== rtl/keypad_event_engine_unit.sv =====
// Top level of the keypad event engine: request/response channels, APB register
// port, per-key state and the key-step sequencer. Depends on kee_pkg, kee_alu, kee_fifo.
`timescale 1ns / 1ps
`default_nettype none

// Keypad event engine. Each request beat is either a scan tick carrying the
// 16 raw key bits (req_type = 0) or a request to pop one event (req_type = 1),
// and each request produces exactly one response beat. In event mode a scan
// tick walks the keys from 0 to 15 and turns edges and held keys into PRESS,
// DOUBLE_CLICK, RELEASE, HOLD and LONG events, which go into a 16-entry queue;
// events that find the queue full are dropped. In simple mode a tick only
// latches the key bits and a pop returns no event. In event mode a scan tick
// takes each of the 16 keys through five steps in one shared increment and
// compare unit before the response is formed; a pop that finds an event
// first reads it from the queue, and other items go straight to forming the
// response. The block takes one request at a time and holds req_stall
// high until the response has been formed; a finished response may wait in
// the output register while the next request is already accepted. Registers
// (APB, always ready): 0x0 event_mode (reset 1), 0x4 hold_threshold (reset 4),
// 0x8 repeat_gap (reset 1). Writing event_mode with a new value clears all
// per-key state and empties the queue. Registers are to be written only while
// the block is idle.
module keypad_event_engine_unit
	import kee_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req_beat,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp_beat,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// One-hot sequencer states. In event mode a tick runs EDGE, DOWN, HOLD, LONG
	// and CLICK once per key; a pop that finds an event runs POP; every item ends in DONE.
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_EDGE  = 8'b0000_0010,
		ST_DOWN  = 8'b0000_0100,
		ST_HOLD  = 8'b0000_1000,
		ST_LONG  = 8'b0001_0000,
		ST_CLICK = 8'b0010_0000,
		ST_POP   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic             event_mode_q;
	logic [CNT_W-1:0] hold_thr_q;
	logic [CNT_W-1:0] repeat_gap_q;

	// Per-key state, read and written at the key under work only; a clear resets every key.
	ph_t              key_phase_q    [NUM_KEYS];
	logic             long_sent_q    [NUM_KEYS];
	logic [CNT_W-1:0] down_count_q   [NUM_KEYS];
	logic [CW_W-1:0]  click_window_q [NUM_KEYS];

	// Tick context and the working copy of the current key.
	logic [15:0]      prev_keys_q;
	logic [15:0]      pressed_q;
	logic [15:0]      released_q;
	logic [KEY_W-1:0] key_q;
	ph_t              ph_q;
	logic             ls_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW_W-1:0]  cw_q;
	logic             pop_hit_q;

	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic              cfg_wr;
	logic              eng_clear;
	logic              req_acc;
	logic              rsp_free;
	logic              last_key;
	logic              key_pressed;
	logic              key_released;
	ph_t               ph_rd;
	logic [CW_W-1:0]   cw_rd;
	alu_req_t          alu_op;
	alu_rsp_t          alu_res;
	push_t             push;
	logic              pop;
	ev_t               pop_ev;
	logic [QCNT_W-1:0] q_count;

	// ------------------------------------------------------------------
	// Register port. A write completes in the access phase; a new
	// event_mode value wipes the engine state, the key latch stays.
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign eng_clear = cfg_wr && (paddr[3:2] == REG_MODE) && (pwdata[0] != event_mode_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_mode_q <= 1'b1;
			hold_thr_q   <= 8'd4;
			repeat_gap_q <= 8'd1;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MODE:   event_mode_q <= pwdata[0];
				REG_THRESH: hold_thr_q   <= pwdata[CNT_W-1:0];
				REG_GAP:    repeat_gap_q <= pwdata[CNT_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_MODE:   prdata = {31'd0, event_mode_q};
			REG_THRESH: prdata = {{(32-CNT_W){1'b0}}, hold_thr_q};
			REG_GAP:    prdata = {{(32-CNT_W){1'b0}}, repeat_gap_q};
			default:    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Handshakes. Requests are taken only while the sequencer is idle; the
	// response register frees up as soon as its beat is taken.
	// ------------------------------------------------------------------
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign last_key  = (key_q == KEY_W'(NUM_KEYS - 1));

	assign ph_rd        = key_phase_q[key_q];
	assign cw_rd        = click_window_q[key_q];
	assign key_pressed  = pressed_q[key_q];
	assign key_released = released_q[key_q];

	// ------------------------------------------------------------------
	// Operand selection for the shared increment-and-compare unit. Each
	// step of the key walk asks it exactly one question.
	// ------------------------------------------------------------------
	always_comb begin
		alu_op = '0;
		unique case (state_q)
			ST_EDGE: begin
				// Is the click window already closed (>= 8)?
				alu_op.cnt = {{(CNT_W-CW_W){1'b0}}, cw_rd};
				alu_op.lim = DOUBLE_WINDOW;
			end
			ST_DOWN: begin
				// Count this tick and test it against the hold threshold.
				alu_op.cnt = cnt_q;
				alu_op.inc = 1'b1;
				alu_op.lim = hold_thr_q;
			end
			ST_HOLD: begin
				// Count again; repeat when count - threshold reaches the gap.
				alu_op.cnt = cnt_q;
				alu_op.inc = 1'b1;
				alu_op.sub = hold_thr_q;
				alu_op.lim = repeat_gap_q;
			end
			ST_LONG: begin
				alu_op.cnt = cnt_q;
				alu_op.lim = LONG_AT;
			end
			ST_CLICK: begin
				// Age the click window and close it at eight ticks.
				alu_op.cnt = {{(CNT_W-CW_W){1'b0}}, cw_q};
				alu_op.inc = 1'b1;
				alu_op.lim = DOUBLE_WINDOW;
			end
			default: alu_op = '0;
		endcase
	end

	kee_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	// ------------------------------------------------------------------
	// Event pushes: at most one per step, so the queue needs one write port.
	// ------------------------------------------------------------------
	always_comb begin
		push.valid   = 1'b0;
		push.ev.key  = key_q;
		push.ev.kind = EV_PRESS;
		unique case (state_q)
			ST_EDGE: begin
				if (key_pressed) begin
					push.valid   = 1'b1;
					push.ev.kind = ((cw_rd != '0) && !alu_res.ge) ? EV_DOUBLE : EV_PRESS;
				end else if (key_released) begin
					push.valid   = 1'b1;
					push.ev.kind = EV_RELEASE;
				end
			end
			ST_DOWN: begin
				push.valid   = (ph_q == PH_DOWN) && alu_res.ge;
				push.ev.kind = EV_HOLD;
			end
			ST_HOLD: begin
				push.valid   = (ph_q == PH_HOLD) && alu_res.ge;
				push.ev.kind = EV_HOLD;
			end
			ST_LONG: begin
				push.valid   = (ph_q == PH_HOLD) && alu_res.ge && !ls_q;
				push.ev.kind = EV_LONG;
			end
			default: push.valid = 1'b0;
		endcase
	end

	assign pop = (state_q == ST_POP);

	kee_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (eng_clear),
		.push    (push),
		.pop     (pop),
		.rd_data (pop_ev),
		.count   (q_count)
	);

	// ------------------------------------------------------------------
	// Sequencer and the working copy of the key under work. EDGE loads the
	// stored key state, the next three steps refine it, and CLICK writes it
	// back before moving on to the next key.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_keys_q <= '0;
			pressed_q   <= '0;
			released_q  <= '0;
			key_q       <= '0;
			ph_q        <= PH_IDLE;
			ls_q        <= 1'b0;
			cnt_q       <= '0;
			cw_q        <= '0;
			pop_hit_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (!req_beat.req_type) begin
							pop_hit_q   <= 1'b0;
							prev_keys_q <= req_beat.raw_keys;
							pressed_q   <= ~prev_keys_q & req_beat.raw_keys;
							released_q  <= prev_keys_q & ~req_beat.raw_keys;
							key_q       <= '0;
							state_q     <= event_mode_q ? ST_EDGE : ST_DONE;
						end else if (event_mode_q && (q_count != '0)) begin
							pop_hit_q <= 1'b1;
							state_q   <= ST_POP;
						end else begin
							pop_hit_q <= 1'b0;
							state_q   <= ST_DONE;
						end
					end
				end
				ST_EDGE: begin
					if (key_pressed) begin
						cw_q  <= ((cw_rd != '0) && !alu_res.ge) ? CW_W'(0) : CW_W'(1);
						ph_q  <= PH_DOWN;
						cnt_q <= '0;
						ls_q  <= 1'b0;
					end else if (key_released) begin
						// A release out of hold leaves the click window as it was.
						cw_q  <= (ph_rd != PH_HOLD) ? CW_W'(1) : cw_rd;
						ph_q  <= PH_IDLE;
						cnt_q <= down_count_q[key_q];
						ls_q  <= long_sent_q[key_q];
					end else begin
						cw_q  <= cw_rd;
						ph_q  <= ph_rd;
						cnt_q <= down_count_q[key_q];
						ls_q  <= long_sent_q[key_q];
					end
					state_q <= ST_DOWN;
				end
				ST_DOWN: begin
					if (ph_q == PH_DOWN) begin
						cnt_q <= alu_res.sum;
						if (alu_res.ge) begin
							ph_q <= PH_HOLD;
						end
					end
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (ph_q == PH_HOLD) begin
						cnt_q <= alu_res.ge ? hold_thr_q : alu_res.sum;
					end
					state_q <= ST_LONG;
				end
				ST_LONG: begin
					if ((ph_q == PH_HOLD) && alu_res.ge) begin
						ls_q <= 1'b1;
					end
					state_q <= ST_CLICK;
				end
				ST_CLICK: begin
					if (last_key) begin
						state_q <= ST_DONE;
					end else begin
						key_q   <= key_q + KEY_W'(1);
						state_q <= ST_EDGE;
					end
				end
				ST_POP: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The response beat is offered once DONE can load the output register,
	// and withdrawn when it is taken with nothing new behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// The click window ages only while the key is up and the window is open.
	logic [CW_W-1:0] cw_next;

	always_comb begin
		cw_next = cw_q;
		if ((ph_q == PH_IDLE) && (cw_q != '0)) begin
			cw_next = alu_res.ge ? CW_W'(0) : alu_res.sum[CW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				key_phase_q[k]    <= PH_IDLE;
				long_sent_q[k]    <= 1'b0;
				down_count_q[k]   <= '0;
				click_window_q[k] <= '0;
			end
		end else if (eng_clear) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				key_phase_q[k]    <= PH_IDLE;
				long_sent_q[k]    <= 1'b0;
				down_count_q[k]   <= '0;
				click_window_q[k] <= '0;
			end
		end else if (state_q == ST_CLICK) begin
			key_phase_q[key_q]    <= ph_q;
			long_sent_q[key_q]    <= ls_q;
			down_count_q[key_q]   <= cnt_q;
			click_window_q[key_q] <= cw_next;
		end
	end

	// ------------------------------------------------------------------
	// Response register. The queue count has settled by DONE, and a popped
	// entry is already in the queue's read register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && rsp_free) begin
			rsp_q.keys_now    <= prev_keys_q;
			rsp_q.event_valid <= pop_hit_q;
			rsp_q.event_key   <= pop_hit_q ? pop_ev.key : 4'd0;
			rsp_q.event_type  <= pop_hit_q ? pop_ev.kind : 3'd0;
			rsp_q.queue_count <= q_count;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_q;

endmodule

`default_nettype wire
